/* rtl/qoi_enc_pkg.sv */
// ----------------------------------------------------------------------------
// QOI encoder package
// Shared constants, chunk opcodes, register indexes and a helper function.
// ----------------------------------------------------------------------------
package qoi_enc_pkg;

  localparam int INDEX_SLOTS = 64;
  localparam int SLOT_W      = $clog2(INDEX_SLOTS);
  localparam int MAX_RUN     = 62;
  localparam int RUN_W       = 6;
  localparam int HDR_LEN     = 14;
  localparam int END_LEN     = 8;
  localparam int CHUNK_MAX   = 5;
  localparam int CNT_W       = 4;
  localparam int LEN_W       = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [31:0] QOI_MAGIC = 32'h716F_6966;  // "qoif"
  localparam logic [31:0] PIXEL_RESET = 32'h0000_00FF;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam logic [7:0] LUMA_BIAS_G  = 8'd30;
  localparam logic [7:0] LUMA_BIAS_RB = 8'd8;
  localparam logic [7:0] DIFF_BIAS    = 8'd2;
  localparam logic [7:0] COLORSPACE   = 8'd1;
  localparam logic [7:0] END_TAIL     = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_RUN,
    PH_CHUNK,
    PH_END
  } phase_t;

  typedef logic [7:0] byte_t;

  // (3r + 5g + 7b + 11a) mod 64, only the low six bits matter
  function automatic logic [SLOT_W-1:0] qoi_hash(byte_t r, byte_t g, byte_t b, byte_t a);
    logic [SLOT_W-1:0] h;
    h = r[SLOT_W-1:0] * SLOT_W'(3) + g[SLOT_W-1:0] * SLOT_W'(5)
      + b[SLOT_W-1:0] * SLOT_W'(7) + a[SLOT_W-1:0] * SLOT_W'(11);
    return h;
  endfunction

endpackage

/* rtl/qoi_enc_if.sv */
// ----------------------------------------------------------------------------
// QOI encoder channels
// Pixel input, byte output and register write channels.
// ----------------------------------------------------------------------------
interface qoi_enc_pixel_if
  import qoi_enc_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t red;
  byte_t green;
  byte_t blue;
  byte_t alpha;
  logic  final_pixel;

  modport source (output valid, red, green, blue, alpha, final_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, final_pixel, output ready);
endinterface

interface qoi_enc_byte_if
  import qoi_enc_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_of_item;
  logic  end_of_stream;

  modport source (output valid, out_byte, last_of_item, end_of_stream, input ready);
  modport sink   (input valid, out_byte, last_of_item, end_of_stream, output ready);
endinterface

interface qoi_enc_cfg_if
  import qoi_enc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/qoi_image_encoder_unit.sv */
// ----------------------------------------------------------------------------
// QOI image encoder
// Streams RGBA pixels in raster order and emits the QOI byte stream.
// ----------------------------------------------------------------------------
// One pixel request enters per cycle unless stalled. A pixel is registered in
// the input stage (color index read), then encoded into a byte job; the job
// register drives the output one byte per cycle while the receiver is ready.
// A pixel yields 0 bytes if it only extends a run, 1 to 6 for chunks, plus 14
// for the header on the first pixel and 8 for the end marker on the final one.
// The single byte output port sets the sustained rate. The user must write
// registers only while no pixel is in flight; the block does not enforce it.
module qoi_image_encoder_unit
  import qoi_enc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  qoi_enc_cfg_if.sink             cfg,
  qoi_enc_pixel_if.sink           pixel,
  qoi_enc_byte_if.source          stream
);

  // configuration
  logic [2:0]  channel_count;
  logic [31:0] image_width;
  logic [31:0] image_height;

  // encoder state
  logic [31:0]            prev_px;
  logic [RUN_W-1:0]       run_len;
  logic                   hdr_pend;
  logic [INDEX_SLOTS-1:0] cidx_vld;
  logic [31:0]            cidx_mem [INDEX_SLOTS];
  logic [31:0]            mem_q;

  // input stage
  logic              s1_valid;
  logic [31:0]       s1_px;
  logic              s1_fin;
  logic [SLOT_W-1:0] s1_slot;
  logic              s1_ent_vld;
  logic              s1_fwd;
  logic [31:0]       s1_fwd_px;

  // byte job
  phase_t            phase;
  phase_t            phase_next;
  phase_t            phase_after;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              job_three;
  logic [31:0]       job_width;
  logic [31:0]       job_height;
  logic              job_run;
  byte_t             job_run_byte;
  byte_t             job_chunk [CHUNK_MAX];
  logic [LEN_W-1:0]  job_len;
  logic              job_end;

  // combinational
  logic              three_in;
  byte_t             alpha_in;
  logic [SLOT_W-1:0] slot_in;
  logic              accept;
  logic              commit;
  logic              load;
  logic              silent;
  logic              job_free;
  logic              seg_last;
  logic              out_fire;
  logic              slot_match;

  byte_t             r, g, b, a, pr, pg, pb, pa;
  byte_t             dr, dg, db, lr, lg, lb;
  logic [31:0]       entry;
  logic              same;
  logic              hit;
  logic              run_emit;
  byte_t             run_byte;
  logic [RUN_W-1:0]  run_len_next;
  byte_t             chunk [CHUNK_MAX];
  logic [LEN_W-1:0]  chunk_len;
  phase_t            start_phase;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 3'd4;
      image_width   <= '0;
      image_height  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHANNELS: channel_count <= cfg.data[2:0];
        REG_WIDTH:    image_width   <= cfg.data;
        REG_HEIGHT:   image_height  <= cfg.data;
        default:      ;
      endcase
    end
  end

  // ----------------------------------------------------------- input stage
  assign three_in    = (channel_count == 3'd3);
  assign alpha_in    = three_in ? 8'hFF : pixel.alpha;
  assign slot_in     = qoi_hash(pixel.red, pixel.green, pixel.blue, alpha_in);
  assign pixel.ready = !s1_valid || commit;
  assign accept      = pixel.valid && pixel.ready;
  assign slot_match  = commit && !same && (s1_slot == slot_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= {pixel.red, pixel.green, pixel.blue, alpha_in};
      s1_fin     <= pixel.final_pixel;
      s1_slot    <= slot_in;
      s1_fwd     <= slot_match;
      s1_fwd_px  <= s1_px;
      // a final pixel clears the index in the same edge
      if (commit && s1_fin) begin
        s1_ent_vld <= 1'b0;
      end else if (slot_match) begin
        s1_ent_vld <= 1'b1;
      end else begin
        s1_ent_vld <= cidx_vld[slot_in];
      end
    end
  end

  // color index memory
  always_ff @(posedge clk) begin
    if (commit && !same) begin
      cidx_mem[s1_slot] <= s1_px;
    end
    if (accept) begin
      mem_q <= cidx_mem[slot_in];
    end
  end

  // ---------------------------------------------------------------- encode
  always_comb begin
    r  = s1_px[31:24];
    g  = s1_px[23:16];
    b  = s1_px[15:8];
    a  = s1_px[7:0];
    pr = prev_px[31:24];
    pg = prev_px[23:16];
    pb = prev_px[15:8];
    pa = prev_px[7:0];

    entry = s1_ent_vld ? (s1_fwd ? s1_fwd_px : mem_q) : '0;
    same  = (s1_px == prev_px);
    hit   = (entry == s1_px);

    dr = r - pr + DIFF_BIAS;
    dg = g - pg + DIFF_BIAS;
    db = b - pb + DIFF_BIAS;
    lr = dr + LUMA_BIAS_RB - dg;
    lb = db + LUMA_BIAS_RB - dg;
    lg = dg + LUMA_BIAS_G;

    if (same) begin
      run_emit = (run_len >= RUN_W'(MAX_RUN - 1)) || s1_fin;
      run_byte = OP_RUN | {2'b00, run_len};
    end else begin
      run_emit = (run_len != '0);
      run_byte = OP_RUN | {2'b00, run_len - RUN_W'(1)};
    end
    run_len_next = (same && !run_emit) ? run_len + RUN_W'(1) : '0;

    for (int i = 0; i < CHUNK_MAX; i++) begin
      chunk[i] = '0;
    end
    chunk_len = '0;
    if (!same) begin
      priority if (hit) begin
        chunk[0]  = OP_INDEX | {2'b00, s1_slot};
        chunk_len = LEN_W'(1);
      end else if (a != pa) begin
        chunk[0]  = OP_RGBA;
        chunk[1]  = r;
        chunk[2]  = g;
        chunk[3]  = b;
        chunk[4]  = a;
        chunk_len = LEN_W'(5);
      end else if (dr < 8'd4 && dg < 8'd4 && db < 8'd4) begin
        chunk[0]  = OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
        chunk_len = LEN_W'(1);
      end else if (lr < 8'd16 && lg < 8'd64 && lb < 8'd16) begin
        chunk[0]  = OP_LUMA | {2'b00, lg[5:0]};
        chunk[1]  = {lr[3:0], lb[3:0]};
        chunk_len = LEN_W'(2);
      end else begin
        chunk[0]  = OP_RGB;
        chunk[1]  = r;
        chunk[2]  = g;
        chunk[3]  = b;
        chunk_len = LEN_W'(4);
      end
    end

    silent = !hdr_pend && !run_emit && (chunk_len == '0) && !s1_fin;

    priority if (hdr_pend) begin
      start_phase = PH_HDR;
    end else if (run_emit) begin
      start_phase = PH_RUN;
    end else if (chunk_len != '0) begin
      start_phase = PH_CHUNK;
    end else begin
      start_phase = PH_END;
    end
  end

  assign commit = s1_valid && (silent || job_free);
  assign load   = commit && !silent;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_px  <= PIXEL_RESET;
      run_len  <= '0;
      hdr_pend <= 1'b1;
      cidx_vld <= '0;
    end else if (commit) begin
      if (s1_fin) begin
        prev_px  <= PIXEL_RESET;
        run_len  <= '0;
        hdr_pend <= 1'b1;
        cidx_vld <= '0;
      end else begin
        prev_px  <= s1_px;
        run_len  <= run_len_next;
        hdr_pend <= 1'b0;
        if (!same) begin
          cidx_vld[s1_slot] <= 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------- byte job
  always_ff @(posedge clk) begin
    if (load) begin
      job_three    <= three_in;
      job_width    <= image_width;
      job_height   <= image_height;
      job_run      <= run_emit;
      job_run_byte <= run_byte;
      job_chunk    <= chunk;
      job_len      <= chunk_len;
      job_end      <= s1_fin;
    end
  end

  assign out_fire = stream.valid && stream.ready;
  assign job_free = (phase == PH_IDLE)
                 || (out_fire && seg_last && (phase_after == PH_IDLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    unique case (phase)
      PH_HDR:   seg_last = (cnt == CNT_W'(HDR_LEN - 1));
      PH_RUN:   seg_last = 1'b1;
      PH_CHUNK: seg_last = (cnt[LEN_W-1:0] == job_len - LEN_W'(1));
      PH_END:   seg_last = (cnt == CNT_W'(END_LEN - 1));
      default:  seg_last = 1'b0;
    endcase

    phase_after = PH_IDLE;
    unique case (phase)
      PH_HDR: begin
        priority if (job_run) begin
          phase_after = PH_RUN;
        end else if (job_len != '0) begin
          phase_after = PH_CHUNK;
        end else if (job_end) begin
          phase_after = PH_END;
        end else begin
          phase_after = PH_IDLE;
        end
      end
      PH_RUN: begin
        priority if (job_len != '0) begin
          phase_after = PH_CHUNK;
        end else if (job_end) begin
          phase_after = PH_END;
        end else begin
          phase_after = PH_IDLE;
        end
      end
      PH_CHUNK: phase_after = job_end ? PH_END : PH_IDLE;
      default:  phase_after = PH_IDLE;
    endcase

    phase_next = phase;
    cnt_next   = cnt;
    if (load) begin
      phase_next = start_phase;
      cnt_next   = '0;
    end else if (out_fire) begin
      if (seg_last) begin
        phase_next = phase_after;
        cnt_next   = '0;
      end else begin
        cnt_next = cnt + CNT_W'(1);
      end
    end
  end

  // outputs
  always_comb begin
    stream.valid         = (phase != PH_IDLE);
    stream.last_of_item  = seg_last && (phase_after == PH_IDLE);
    stream.end_of_stream = (phase == PH_END) && seg_last;
    stream.out_byte      = '0;
    unique case (phase)
      PH_HDR: begin
        unique case (cnt)
          4'd0:    stream.out_byte = QOI_MAGIC[31:24];
          4'd1:    stream.out_byte = QOI_MAGIC[23:16];
          4'd2:    stream.out_byte = QOI_MAGIC[15:8];
          4'd3:    stream.out_byte = QOI_MAGIC[7:0];
          4'd4:    stream.out_byte = job_width[31:24];
          4'd5:    stream.out_byte = job_width[23:16];
          4'd6:    stream.out_byte = job_width[15:8];
          4'd7:    stream.out_byte = job_width[7:0];
          4'd8:    stream.out_byte = job_height[31:24];
          4'd9:    stream.out_byte = job_height[23:16];
          4'd10:   stream.out_byte = job_height[15:8];
          4'd11:   stream.out_byte = job_height[7:0];
          4'd12:   stream.out_byte = job_three ? 8'd3 : 8'd4;
          4'd13:   stream.out_byte = COLORSPACE;
          default: stream.out_byte = '0;
        endcase
      end
      PH_RUN:   stream.out_byte = job_run_byte;
      PH_CHUNK: begin
        if (cnt < CNT_W'(CHUNK_MAX)) begin
          stream.out_byte = job_chunk[cnt[LEN_W-1:0]];
        end
      end
      PH_END:   stream.out_byte = seg_last ? END_TAIL : 8'h00;
      default:  stream.out_byte = '0;
    endcase
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// QOI image encoder testbench
// Pixel requests go in with bursty gaps while the byte side stalls on its own
// pattern. Every accepted pixel is run through a local encoder model, and each
// byte that leaves the block is matched against the oldest predicted byte. A
// short table of hand-checked pixels comes first, then random images.
// ----------------------------------------------------------------------------
module tb;
  import qoi_enc_pkg::*;

  localparam int         SETTLE_CYCLES = 16;
  localparam int         TAIL_CYCLES   = 40;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         RAND_PIXELS   = 210;
  localparam int         DIR_ROWS      = 24;
  localparam logic [2:0] CH_RGB        = 3'd3;
  localparam logic [2:0] CH_RGBA       = 3'd4;
  localparam logic [2:0] CH_TOP        = 3'd7;

  typedef struct packed {
    byte_t r;
    byte_t g;
    byte_t b;
    byte_t a;
  } rgba_t;

  typedef struct packed {
    byte_t data;
    logic  last;
    logic  eos;
  } qoi_byte_t;

  typedef enum logic { ROW_REG, ROW_PIXEL } row_kind_e;
  typedef enum logic [1:0] { RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKS } rx_mode_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          reg_val;
    rgba_t                px;
    logic                 fin;
    int                   reps;
    int                   exp_n;
    byte_t                exp_tail;
  } dir_row_t;

  // typed byte count and final byte of each pixel row
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{ROW_REG,   REG_CHANNELS, 32'd4,         32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_REG,   REG_WIDTH,    32'hFFFF_FFFF, 32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_REG,   REG_HEIGHT,   32'd0,         32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h000000FF,  1'b0, 1,  14, 8'h01},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h000000FF,  1'b0, 1,  0,  8'h00},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h010101FF,  1'b0, 1,  2,  8'h7F},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h000000FF,  1'b0, 1,  1,  8'h55},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h010101FF,  1'b0, 1,  1,  8'h04},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'hFFFFFF00,  1'b0, 1,  5,  8'h00},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'hFFFFFFFF,  1'b0, 1,  5,  8'hFF},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h0A0808FF,  1'b0, 1,  2,  8'hA8},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h6400C8FF,  1'b0, 1,  4,  8'hC8},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h6400C8FF,  1'b0, 62, 1,  8'hFD},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h6400C8FF,  1'b1, 1,  9,  8'h01},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h01020304,  1'b1, 1,  27, 8'h01},
    '{ROW_REG,   REG_CHANNELS, 32'd3,         32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_REG,   REG_WIDTH,    32'd0,         32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_REG,   REG_HEIGHT,   32'hFFFF_FFFF, 32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h05060700,  1'b0, 1,  16, 8'h79},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h0506077B,  1'b1, 1,  9,  8'h01},
    '{ROW_REG,   REG_CHANNELS, 32'd7,         32'h0,         1'b0, 0,  0,  8'h00},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h01020304,  1'b1, 1,  27, 8'h01},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'hFEFEFEFF,  1'b0, 1,  15, 8'h40},
    '{ROW_PIXEL, REG_CHANNELS, 32'h0,         32'h000000FF,  1'b1, 1,  10, 8'h01}
  };

  logic clk;
  logic rst;

  qoi_enc_cfg_if   cfg_bus ();
  qoi_enc_pixel_if pixel_bus ();
  qoi_enc_byte_if  byte_bus ();

  qoi_image_encoder_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .pixel  (pixel_bus),
    .stream (byte_bus)
  );

  // encoder model state
  rgba_t       seen_colors [INDEX_SLOTS];
  rgba_t       prev_color;
  int          run_count;
  logic        header_due;
  logic [2:0]  chan_cfg;
  logic [31:0] img_w;
  logic [31:0] img_h;

  qoi_byte_t pixel_bytes [$];
  qoi_byte_t stream_bytes_due [$];
  qoi_byte_t want_byte;

  rgba_t last_px;
  rgba_t recent_px [8];
  int    recent_wr;
  int    burst_left;

  int errors;
  int pixels_sent;
  int bytes_checked;
  int images_done;
  int regs_written;
  int n_run, n_index, n_diff, n_luma, n_rgb, n_rgba;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void note_mismatch(string what, int want, int got);
    if (errors < 40)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    errors++;
  endfunction

  function automatic void put_byte(byte_t v);
    qoi_byte_t nb;
    nb = '{v, 1'b0, 1'b0};
    pixel_bytes = {pixel_bytes, nb};
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) put_byte(w[8*k +: 8]);
  endfunction

  function automatic void flush_run();
    put_byte(OP_RUN | byte_t'(run_count - 1));
    run_count = 0;
    n_run++;
  endfunction

  function automatic void reset_image_state();
    foreach (seen_colors[k]) seen_colors[k] = '0;
    prev_color = PIXEL_RESET;
    run_count  = 0;
    header_due = 1'b1;
  endfunction

  // bytes one accepted pixel adds to the stream
  task automatic encode_pixel(input rgba_t in_px, input logic fin, output int n,
                              output byte_t tail);
    rgba_t       px;
    logic [31:0] hsum;
    logic [5:0]  slot;
    byte_t       dr, dg, db, lr, lg, lb;
    bit          rgb_mode;
    rgb_mode = (chan_cfg == CH_RGB);
    px = in_px;
    if (rgb_mode) px.a = 8'hFF;
    pixel_bytes.delete();
    if (header_due) begin
      put_word(QOI_MAGIC);
      put_word(img_w);
      put_word(img_h);
      put_byte(byte_t'(rgb_mode ? CH_RGB : CH_RGBA));
      put_byte(COLORSPACE);
      header_due = 1'b0;
    end
    if (px == prev_color) begin
      run_count++;
      if (run_count >= MAX_RUN || fin) flush_run();
    end else begin
      if (run_count > 0) flush_run();
      hsum = 32'(px.r) * 3 + 32'(px.g) * 5 + 32'(px.b) * 7 + 32'(px.a) * 11;
      slot = 6'(hsum % INDEX_SLOTS);
      if (seen_colors[slot] == px) begin
        put_byte(OP_INDEX | {2'b00, slot});
        n_index++;
      end else begin
        seen_colors[slot] = px;
        if (px.a == prev_color.a) begin
          dr = px.r - prev_color.r + DIFF_BIAS;
          dg = px.g - prev_color.g + DIFF_BIAS;
          db = px.b - prev_color.b + DIFF_BIAS;
          lr = dr + LUMA_BIAS_RB - dg;
          lb = db + LUMA_BIAS_RB - dg;
          lg = dg + LUMA_BIAS_G;
          if (dr < 4 && dg < 4 && db < 4) begin
            put_byte(OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]});
            n_diff++;
          end else if (lr < 16 && lg < 64 && lb < 16) begin
            put_byte(OP_LUMA | lg);
            put_byte({lr[3:0], lb[3:0]});
            n_luma++;
          end else begin
            put_byte(OP_RGB);
            put_byte(px.r);
            put_byte(px.g);
            put_byte(px.b);
            n_rgb++;
          end
        end else begin
          put_byte(OP_RGBA);
          put_byte(px.r);
          put_byte(px.g);
          put_byte(px.b);
          put_byte(px.a);
          n_rgba++;
        end
      end
      prev_color = px;
    end
    if (fin) begin
      repeat (END_LEN - 1) put_byte(8'h00);
      put_byte(END_TAIL);
      pixel_bytes[pixel_bytes.size() - 1].eos = 1'b1;
      reset_image_state();
      images_done++;
    end
    n    = pixel_bytes.size();
    tail = 8'h00;
    if (n > 0) begin
      pixel_bytes[n - 1].last = 1'b1;
      tail = pixel_bytes[n - 1].data;
    end
    stream_bytes_due = {stream_bytes_due, pixel_bytes};
  endtask

  task automatic send_pixel(input rgba_t px, input logic fin, output int n,
                            output byte_t tail);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(30, 90);
      end else begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 20);
      end
      if (gap > 0) begin
        pixel_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_bus.valid       <= 1'b1;
    pixel_bus.red         <= px.r;
    pixel_bus.green       <= px.g;
    pixel_bus.blue        <= px.b;
    pixel_bus.alpha       <= px.a;
    pixel_bus.final_pixel <= fin;
    @(posedge clk);
    while (!pixel_bus.ready) @(posedge clk);
    encode_pixel(px, fin, n, tail);
    last_px = px;
    recent_px[recent_wr] = px;
    recent_wr = (recent_wr + 1) % 8;
    pixels_sent++;
  endtask

  // hold pixels back until every predicted byte has left the block
  task automatic wait_for_idle();
    pixel_bus.valid <= 1'b0;
    do @(posedge clk); while (stream_bytes_due.size() != 0);
  endtask

  task automatic drain_stream();
    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves valid high so back-to-back writes stay one request each cycle
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_CHANNELS: chan_cfg = val[2:0];
      REG_WIDTH:    img_w = val;
      REG_HEIGHT:   img_h = val;
      default: ;
    endcase
    regs_written++;
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && byte_bus.valid && byte_bus.ready) begin
      bytes_checked++;
      if (stream_bytes_due.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected byte, expected none, actual %02h", $time,
                   byte_bus.out_byte);
        errors++;
      end else begin
        want_byte = stream_bytes_due.pop_front();
        if (byte_bus.out_byte !== want_byte.data)
          note_mismatch("out_byte", want_byte.data, byte_bus.out_byte);
        if (byte_bus.last_of_item !== want_byte.last)
          note_mismatch("last_of_item", want_byte.last, byte_bus.last_of_item);
        if (byte_bus.end_of_stream !== want_byte.eos)
          note_mismatch("end_of_stream", want_byte.eos, byte_bus.end_of_stream);
      end
    end
  end

  initial begin : receiver
    rx_mode_e rx_mode;
    int       mode_left;
    int       block_left;
    int       period;
    int       tick;
    byte_bus.ready <= 1'b0;
    rx_mode    = RX_OPEN;
    mode_left  = 0;
    block_left = 0;
    period     = 2;
    tick       = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
        period    = $urandom_range(2, 5);
      end
      mode_left--;
      tick++;
      case (rx_mode)
        RX_OPEN:     byte_bus.ready <= 1'b1;
        RX_RANDOM:   byte_bus.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: byte_bus.ready <= ((tick % period) != 0);
        default: begin
          if (block_left > 0) begin
            block_left--;
            byte_bus.ready <= 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            block_left = $urandom_range(1, 8);
            byte_bus.ready <= 1'b0;
          end else begin
            byte_bus.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_bus.valid && pixel_bus.ready) || (byte_bus.valid && byte_bus.ready)
          || (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no request accepted for %0d cycles, %0d bytes still due", $time,
             STALL_LIMIT, stream_bytes_due.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int    n, row_n, npix, long_at, pick, rand_start;
    byte_t tail, row_tail, dgv;
    rgba_t px;
    bit    first_img;
    rst                   <= 1'b1;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_CHANNELS;
    cfg_bus.data          <= 32'd0;
    pixel_bus.valid       <= 1'b0;
    pixel_bus.red         <= 8'h00;
    pixel_bus.green       <= 8'h00;
    pixel_bus.blue        <= 8'h00;
    pixel_bus.alpha       <= 8'h00;
    pixel_bus.final_pixel <= 1'b0;
    errors        = 0;
    pixels_sent   = 0;
    bytes_checked = 0;
    images_done   = 0;
    regs_written  = 0;
    {n_run, n_index, n_diff, n_luma, n_rgb, n_rgba} = '0;
    burst_left = 0;
    recent_wr  = 0;
    last_px    = PIXEL_RESET;
    foreach (recent_px[k]) recent_px[k] = PIXEL_RESET;
    chan_cfg = CH_RGBA;
    img_w    = 32'd0;
    img_h    = 32'd0;
    reset_image_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int row = 0; row < DIR_ROWS; row++) begin
      if (dir_tab[row].kind == ROW_REG) begin
        drain_stream();
        program_reg(dir_tab[row].reg_idx, dir_tab[row].reg_val);
        cfg_bus.valid <= 1'b0;
      end else begin
        row_n    = 0;
        row_tail = 8'h00;
        repeat (dir_tab[row].reps) begin
          send_pixel(dir_tab[row].px, dir_tab[row].fin, n, tail);
          row_n += n;
          if (n > 0) row_tail = tail;
        end
        if (row_n != dir_tab[row].exp_n)
          note_mismatch($sformatf("row %0d byte count", row), dir_tab[row].exp_n, row_n);
        if (row_n > 0 && row_tail != dir_tab[row].exp_tail)
          note_mismatch($sformatf("row %0d last byte", row), dir_tab[row].exp_tail, row_tail);
      end
    end

    rand_start = pixels_sent;
    first_img  = 1'b1;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      drain_stream();
      case ($urandom_range(0, 6))
        0, 1:    program_reg(REG_CHANNELS, 32'(CH_RGBA));
        2, 3:    program_reg(REG_CHANNELS, 32'(CH_RGB));
        4:       program_reg(REG_CHANNELS, 32'd0);
        5:       program_reg(REG_CHANNELS, 32'(CH_TOP));
        default: program_reg(REG_CHANNELS, 32'($urandom_range(0, 7)));
      endcase
      if (first_img || $urandom_range(0, 1) == 0) program_reg(REG_WIDTH, pick_dim());
      if (first_img || $urandom_range(0, 1) == 0) program_reg(REG_HEIGHT, pick_dim());
      cfg_bus.valid <= 1'b0;
      first_img = 1'b0;

      npix    = $urandom_range(1, 24);
      long_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, npix - 1) : -1;
      for (int i = 0; i < npix; i++) begin
        if (i == long_at)
          repeat ($urandom_range(58, 70)) send_pixel(last_px, 1'b0, n, tail);
        pick = $urandom_range(0, 99);
        px   = last_px;
        if (pick < 42) begin
          if (pick >= 25) begin
            px.r = last_px.r + byte_t'($urandom_range(0, 3)) - 8'd2;
            px.g = last_px.g + byte_t'($urandom_range(0, 3)) - 8'd2;
            px.b = last_px.b + byte_t'($urandom_range(0, 3)) - 8'd2;
          end
        end else if (pick < 57) begin
          dgv  = byte_t'($urandom_range(0, 63)) - 8'd32;
          px.g = last_px.g + dgv;
          px.r = last_px.r + dgv + byte_t'($urandom_range(0, 15)) - 8'd8;
          px.b = last_px.b + dgv + byte_t'($urandom_range(0, 15)) - 8'd8;
        end else if (pick < 70) begin
          px = recent_px[$urandom_range(0, 7)];
        end else if (pick < 90) begin
          px = rgba_t'($urandom);
        end else begin
          px.a = byte_t'($urandom);
        end
        if ($urandom_range(0, 31) == 0) wait_for_idle();
        send_pixel(px, (i == npix - 1), n, tail);
      end
    end

    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stream_bytes_due.size() != 0) note_mismatch("bytes left due", 0, stream_bytes_due.size());

    $display("encoded %0d pixels in %0d images, %0d register writes, %0d stream bytes checked",
             pixels_sent, images_done, regs_written, bytes_checked);
    $display("chunks seen: run %0d, index %0d, diff %0d, luma %0d, rgb %0d, rgba %0d",
             n_run, n_index, n_diff, n_luma, n_rgb, n_rgba);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
